// ===== sv/rlcps_pkg.sv =====
// Shared types, constants and the colour decode for the LED PWM serializer.
`default_nettype none

package rlcps_pkg;

	localparam int BITS_PER_LED = 24;
	localparam int MAX_LATCH    = 64;
	localparam int CNT_W        = 7;
	localparam int DUTY_W       = 10;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_IDX_W    = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_SLOTS = 2'd3;

	// Reset values of the configuration registers
	localparam logic [7:0]        BRIGHTNESS_RST  = 8'd30;
	localparam logic [DUTY_W-1:0] ONE_DUTY_RST    = 10'd60;
	localparam logic [DUTY_W-1:0] ZERO_DUTY_RST   = 10'd30;
	localparam logic [CNT_W-1:0]  LATCH_SLOTS_RST = 7'd50;

	// Input op codes
	localparam logic OP_LED = 1'b0;
	localparam logic OP_EOF = 1'b1;

	// LED state codes: bit2 red, bit1 green, bit0 blue
	localparam logic [2:0] CODE_OFF    = 3'b000;
	localparam logic [2:0] CODE_BLUE   = 3'b001;
	localparam logic [2:0] CODE_GREEN  = 3'b010;
	localparam logic [2:0] CODE_RED    = 3'b100;
	localparam logic [2:0] CODE_YELLOW = 3'b110;
	localparam logic [2:0] CODE_WHITE  = 3'b111;

	typedef struct packed {
		logic [7:0]        brightness;
		logic [DUTY_W-1:0] one_duty;
		logic [DUTY_W-1:0] zero_duty;
		logic [CNT_W-1:0]  latch_slots;
	} cfg_t;

	// One run of slots for the back end
	typedef struct packed {
		logic                    latch;
		logic [CNT_W-1:0]        cnt;
		logic [BITS_PER_LED-1:0] colour;
	} cmd_t;

	// Colour word G<<16 | R<<8 | B; the keep codes return the stored colour
	function automatic logic [BITS_PER_LED-1:0] colour_for(
		input logic [2:0]              code,
		input logic [7:0]              bright,
		input logic [BITS_PER_LED-1:0] old
	);
		logic [BITS_PER_LED-1:0] c;
		begin
			case (code)
				CODE_OFF:    c = '0;
				CODE_RED:    c = {8'd0, bright, 8'd0};
				CODE_GREEN:  c = {bright, 8'd0, 8'd0};
				CODE_BLUE:   c = {8'd0, 8'd0, bright};
				CODE_YELLOW: c = {bright, bright, 8'd0};
				CODE_WHITE:  c = {bright, bright, bright};
				default:     c = old;
			endcase
			return c;
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/rlcps_front.sv =====
// Front end: accepts items, tracks the LED index, updates the colour store, issues runs.
`default_nettype none

module rlcps_front #(
	parameter int LED_SLOTS = 20
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic                      op,
	input  wire logic [2:0]                code,
	input  wire rlcps_pkg::cfg_t           cfg,
	output logic                           cmd_push,
	output rlcps_pkg::cmd_t                cmd,
	input  wire logic                      cmd_full
);

	localparam int IDX_W = $clog2(LED_SLOTS + 1);
	localparam int AW    = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
	localparam int CW    = rlcps_pkg::BITS_PER_LED;

	logic [CW-1:0]    mem [LED_SLOTS];
	logic [LED_SLOTS-1:0] vld_q;

	logic [IDX_W-1:0] idx_q;
	logic             in_range;
	logic             accept;
	logic             done;
	logic             wr_en;

	logic             valid_s1;
	logic             op_s1;
	logic [2:0]       code_s1;
	logic             inr_s1;
	logic [AW-1:0]    addr_s1;
	logic [CW-1:0]    rdata_s1;
	logic             rvld_s1;

	logic [CW-1:0]    old_colour;
	logic [CW-1:0]    new_colour;
	logic [rlcps_pkg::CNT_W-1:0] latch_cnt;

	assign in_range = (idx_q < IDX_W'(LED_SLOTS));

	assign old_colour = rvld_s1 ? rdata_s1 : '0;
	assign new_colour = rlcps_pkg::colour_for(code_s1, cfg.brightness, old_colour);
	assign latch_cnt  = (cfg.latch_slots > rlcps_pkg::CNT_W'(rlcps_pkg::MAX_LATCH))
		? rlcps_pkg::CNT_W'(rlcps_pkg::MAX_LATCH) : cfg.latch_slots;

	always_comb begin
		cmd_push = 1'b0;
		cmd = '0;
		if (op_s1 == rlcps_pkg::OP_EOF) begin
			cmd.latch = 1'b1;
			cmd.cnt   = latch_cnt;
			cmd_push  = valid_s1 && (latch_cnt != '0);
		end else begin
			cmd.latch  = 1'b0;
			cmd.cnt    = rlcps_pkg::CNT_W'(rlcps_pkg::BITS_PER_LED);
			cmd.colour = new_colour;
			cmd_push   = valid_s1 && inr_s1;
		end
	end

	// Hold the item in stage 1 until its run fits in the queue
	assign done   = !cmd_push || !cmd_full;
	assign full   = valid_s1 && !done;
	assign accept = push && !full;
	assign wr_en  = valid_s1 && done && (op_s1 == rlcps_pkg::OP_LED) && inr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			vld_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (op == rlcps_pkg::OP_EOF) begin
					idx_q <= '0;
				end else if (in_range) begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			code_s1 <= code;
			inr_s1  <= in_range;
			addr_s1 <= idx_q[AW-1:0];
			if (in_range) begin
				rdata_s1 <= mem[idx_q[AW-1:0]];
				rvld_s1  <= vld_q[idx_q[AW-1:0]];
			end else begin
				rvld_s1  <= 1'b0;
			end
		end
		if (wr_en) begin
			mem[addr_s1] <= new_colour;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rlcps_cmd_fifo.sv =====
// Two-entry queue of runs between the front and back ends.
`default_nettype none

module rlcps_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire rlcps_pkg::cmd_t wdata,
	output logic                 full,
	input  wire logic            rd,
	output rlcps_pkg::cmd_t      rdata,
	output logic                 empty
);

	rlcps_pkg::cmd_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rlcps_back.sv =====
// Back end: plays a run out as duty slots into a two-entry result queue, one per cycle while it has room.
`default_nettype none

module rlcps_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rlcps_pkg::cmd_t                 cmd,
	input  wire logic                            cmd_empty,
	output logic                                 cmd_pop,
	input  wire rlcps_pkg::cfg_t                 cfg,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [rlcps_pkg::DUTY_W-1:0]         duty,
	output logic                                 last
);

	localparam int DW = rlcps_pkg::DUTY_W;
	localparam int CW = rlcps_pkg::BITS_PER_LED;

	logic                        busy_q;
	logic                        latch_q;
	logic [rlcps_pkg::CNT_W-1:0] rem_q;
	logic [CW-1:0]               sr_q;

	logic [DW-1:0] od_q [2];
	logic          ol_q [2];
	logic          owp_q;
	logic          orp_q;
	logic [1:0]    ocnt_q;

	logic          emit;
	logic          opop;
	logic          fin;
	logic [DW-1:0] slot_duty;
	logic          slot_last;

	assign emit    = busy_q && (ocnt_q != 2'd2);
	assign fin     = emit && (rem_q == rlcps_pkg::CNT_W'(1));
	assign cmd_pop = !cmd_empty && (!busy_q || fin);
	assign opop    = pop && !empty;

	assign slot_duty = latch_q ? '0 : (sr_q[CW-1] ? cfg.one_duty : cfg.zero_duty);
	assign slot_last = (rem_q == rlcps_pkg::CNT_W'(1));

	assign empty = (ocnt_q == 2'd0);
	assign duty  = od_q[orp_q];
	assign last  = ol_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				owp_q <= ~owp_q;
			end
			if (opop) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, emit} - {1'b0, opop};
		end
	end

	// Load a new run, or advance the current one by a slot
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			latch_q <= cmd.latch;
			rem_q   <= cmd.cnt;
			sr_q    <= cmd.colour;
		end else if (emit) begin
			rem_q <= rem_q - 1'b1;
			sr_q  <= {sr_q[CW-2:0], 1'b0};
		end
		if (emit) begin
			od_q[owp_q] <= slot_duty;
			ol_q[owp_q] <= slot_last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rgb_led_code_pwm_serializer.sv =====
// Top level of the LED code to PWM duty slot serializer.
//
//  channel   direction  handshake          payload
//  item      in         push / full        op, code
//  result    out        pop / empty        duty, last
//  config    in         cfg_wen            cfg_idx, cfg_data
//
// An in-chain LED request yields 24 slots, set by the back end's slot counter, one per
// cycle while results have room; EOF yields min(latch_slots, 64) zero slots, none if zero.
// The front end takes a new request every cycle until the two-entry run queue fills,
// so a request is taken while the previous run is still playing out.
// Reset clears the colour store's valid bits, the LED index and both queues at once.
// A stalled result side holds the result queue; slots resume with no loss.
`default_nettype none

module rgb_led_code_pwm_serializer #(
	parameter int LED_SLOTS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              op,
	input  wire logic [2:0]                        code,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [rlcps_pkg::DUTY_W-1:0]           duty,
	output logic                                   last,
	input  wire logic                              cfg_wen,
	input  wire logic [rlcps_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [rlcps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rlcps_pkg::cfg_t cfg_q;
	rlcps_pkg::cmd_t cmd_in;
	rlcps_pkg::cmd_t cmd_out;
	logic            cmd_push;
	logic            cmd_full;
	logic            cmd_pop;
	logic            cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness  <= rlcps_pkg::BRIGHTNESS_RST;
			cfg_q.one_duty    <= rlcps_pkg::ONE_DUTY_RST;
			cfg_q.zero_duty   <= rlcps_pkg::ZERO_DUTY_RST;
			cfg_q.latch_slots <= rlcps_pkg::LATCH_SLOTS_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				rlcps_pkg::REG_BRIGHTNESS:  cfg_q.brightness  <= cfg_data[7:0];
				rlcps_pkg::REG_ONE_DUTY:    cfg_q.one_duty    <= cfg_data;
				rlcps_pkg::REG_ZERO_DUTY:   cfg_q.zero_duty   <= cfg_data;
				rlcps_pkg::REG_LATCH_SLOTS: cfg_q.latch_slots <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	rlcps_front #(
		.LED_SLOTS(LED_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.code     (code),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	rlcps_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	rlcps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.duty      (duty),
		.last      (last)
	);

	a_full_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cmd_full)
		else $error("front stalls while the run queue has room");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("back end takes a run from an empty queue");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_full && cmd_pop) |=> !cmd_full || $past(cmd_push))
		else $error("run queue stays full after a take with no new run");

endmodule

`default_nettype wire

// ===== dv/tb_rgb_led_code_pwm_serializer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LED code to PWM duty slot serializer.
module tb_rgb_led_code_pwm_serializer;

	localparam int CHAIN_LEN   = 20;
	localparam int LIMIT       = 1000000;
	localparam int SETTLE      = 80;
	localparam int MAX_REPORTS = 40;

	// Codes that keep the stored colour
	localparam logic [2:0] CODE_KEEP_GB = 3'b011;
	localparam logic [2:0] CODE_KEEP_RB = 3'b101;

	typedef struct packed {
		logic [rlcps_pkg::DUTY_W-1:0] duty;
		logic                         last;
	} slot_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             push     = 1'b0;
	logic                             op       = rlcps_pkg::OP_LED;
	logic [2:0]                       code     = rlcps_pkg::CODE_OFF;
	logic                             pop      = 1'b0;
	logic                             cfg_wen  = 1'b0;
	logic [rlcps_pkg::CFG_IDX_W-1:0]  cfg_idx  = rlcps_pkg::REG_BRIGHTNESS;
	logic [rlcps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                             full;
	logic                             empty;
	logic [rlcps_pkg::DUTY_W-1:0]     duty;
	logic                             last;

	// Predictor state and configuration shadow
	logic [rlcps_pkg::BITS_PER_LED-1:0] led_colour [CHAIN_LEN];
	int                                 led_pos;
	logic [7:0]                         bright_cfg;
	logic [rlcps_pkg::DUTY_W-1:0]       one_cfg;
	logic [rlcps_pkg::DUTY_W-1:0]       zero_cfg;
	logic [rlcps_pkg::CNT_W-1:0]        latch_cfg;
	slot_t                              pending_slots [$];

	int   mismatch_count = 0;
	int   cycle_count    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_request   = 0;
	logic stall_active   = 1'b0;

	rgb_led_code_pwm_serializer #(
		.LED_SLOTS(CHAIN_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.op      (op),
		.code    (code),
		.empty   (empty),
		.pop     (pop),
		.duty    (duty),
		.last    (last),
		.cfg_wen (cfg_wen),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("tb_rgb_led_code_pwm_serializer: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	// Expected duty slots for one accepted request
	function void encode_request(input logic req_op, input logic [2:0] req_code);
		logic [rlcps_pkg::BITS_PER_LED-1:0] colour;
		slot_t                              s;
		int                                 n;
		if (req_op == rlcps_pkg::OP_EOF) begin
			n = (latch_cfg > rlcps_pkg::MAX_LATCH) ? rlcps_pkg::MAX_LATCH : int'(latch_cfg);
			for (int i = 0; i < n; i++) begin
				s.duty = '0;
				s.last = (i == n - 1);
				pending_slots.push_back(s);
			end
			led_pos = 0;
		end else if (led_pos < CHAIN_LEN) begin
			if (req_code == CODE_KEEP_GB || req_code == CODE_KEEP_RB) begin
				colour = led_colour[led_pos];
			end else begin
				// GRB word: green from bit1, red from bit2, blue from bit0
				colour = {req_code[1] ? bright_cfg : 8'd0,
					req_code[2] ? bright_cfg : 8'd0,
					req_code[0] ? bright_cfg : 8'd0};
			end
			led_colour[led_pos] = colour;
			for (int b = rlcps_pkg::BITS_PER_LED - 1; b >= 0; b--) begin
				s.duty = colour[b] ? one_cfg : zero_cfg;
				s.last = (b == 0);
				pending_slots.push_back(s);
			end
			led_pos++;
		end
	endfunction

	task automatic send_request(input logic req_op, input logic [2:0] req_code);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		op   = req_op;
		code = req_code;
		do @(posedge clk); while (full);
		encode_request(req_op, req_code);
		@(negedge clk);
		push = 1'b0;
	endtask

	// Result side: random stalls, long hold when requested, check every slot
	initial begin
		slot_t want;
		wait (arst_n);
		forever begin
			@(negedge clk);
			pop = !stall_active && ($urandom_range(0, 99) >= recv_stall_pct);
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_slots.size() == 0) begin
					report_mismatch("slot with no request pending", duty, 0);
				end else begin
					want = pending_slots.pop_front();
					if (duty !== want.duty) report_mismatch("duty", duty, want.duty);
					if (last !== want.last) report_mismatch("last", last, want.last);
				end
			end
		end
	end

	// Count out a long receiver hold-off
	initial begin
		forever begin
			wait (hold_request != 0);
			stall_active = 1'b1;
			repeat (hold_request) @(posedge clk);
			stall_active = 1'b0;
			hold_request = 0;
		end
	end

	// Drain all slots, let trailing no-result requests finish, land on a falling edge
	task automatic wait_idle();
		while (pending_slots.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [rlcps_pkg::CFG_IDX_W-1:0] idx,
		input logic [rlcps_pkg::CFG_DATA_W-1:0] data);
		cfg_wen  = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			rlcps_pkg::REG_BRIGHTNESS:  bright_cfg = data[7:0];
			rlcps_pkg::REG_ONE_DUTY:    one_cfg    = data;
			rlcps_pkg::REG_ZERO_DUTY:   zero_cfg   = data;
			rlcps_pkg::REG_LATCH_SLOTS: latch_cfg  = data[rlcps_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int bright, input int one, input int zero, input int latch);
		wait_idle();
		write_reg(rlcps_pkg::REG_BRIGHTNESS, rlcps_pkg::CFG_DATA_W'(bright));
		write_reg(rlcps_pkg::REG_ONE_DUTY, rlcps_pkg::CFG_DATA_W'(one));
		write_reg(rlcps_pkg::REG_ZERO_DUTY, rlcps_pkg::CFG_DATA_W'(zero));
		write_reg(rlcps_pkg::REG_LATCH_SLOTS, rlcps_pkg::CFG_DATA_W'(latch));
	endtask

	function automatic int pick_level(input int hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// Every code from reset settings, then keep codes against a stored frame
	task automatic test_directed_codes();
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_OFF);
		for (int c = 0; c < 8; c++) begin
			send_request(rlcps_pkg::OP_LED, 3'(c));
		end
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_WHITE);
		send_request(rlcps_pkg::OP_LED, rlcps_pkg::CODE_WHITE);
		send_request(rlcps_pkg::OP_LED, CODE_KEEP_GB);
		send_request(rlcps_pkg::OP_LED, CODE_KEEP_RB);
	endtask

	// Extreme settings: empty latch, over-long latch, full and zero duties
	task automatic test_config_extremes();
		set_config(255, 1023, 0, 0);
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_RED);
		send_request(rlcps_pkg::OP_LED, rlcps_pkg::CODE_WHITE);
		send_request(rlcps_pkg::OP_LED, rlcps_pkg::CODE_OFF);
		send_request(rlcps_pkg::OP_LED, rlcps_pkg::CODE_RED);
		set_config(0, 0, 1023, 127);
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_OFF);
		send_request(rlcps_pkg::OP_LED, rlcps_pkg::CODE_WHITE);
		send_request(rlcps_pkg::OP_LED, CODE_KEEP_RB);
		set_config(170, 682, 341, 64);
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_BLUE);
	endtask

	// Run past the end of the chain, then rewind
	task automatic test_beyond_chain();
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_OFF);
		repeat (CHAIN_LEN + 2) send_request(rlcps_pkg::OP_LED, 3'($urandom_range(0, 7)));
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_OFF);
	endtask

	// Hold the result side while requests keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(rlcps_pkg::OP_EOF, rlcps_pkg::CODE_OFF);
		hold_request = 300;
		wait (stall_active);
		repeat (12) send_request(rlcps_pkg::OP_LED, 3'($urandom_range(0, 7)));
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
		int         sent;
		int         len;
		logic       req_op;
		sent = 0;
		set_config(pick_level(255), pick_level(1023), pick_level(1023), pick_level(127));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 85) begin
				// well-formed frame of random length with random codes
				len = $urandom_range(0, CHAIN_LEN + 2);
				repeat (len) begin
					if (led_pos < CHAIN_LEN) sent++;
					send_request(rlcps_pkg::OP_LED, 3'($urandom_range(0, 7)));
				end
				send_request(rlcps_pkg::OP_EOF, 3'($urandom_range(0, 7)));
				sent++;
			end else begin
				req_op = ($urandom_range(0, 9) < 3) ? rlcps_pkg::OP_EOF : rlcps_pkg::OP_LED;
				if (req_op == rlcps_pkg::OP_EOF || led_pos < CHAIN_LEN) sent++;
				send_request(req_op, 3'($urandom_range(0, 7)));
			end
		end
	endtask

	initial begin
		foreach (led_colour[i]) led_colour[i] = '0;
		led_pos    = 0;
		bright_cfg = rlcps_pkg::BRIGHTNESS_RST;
		one_cfg    = rlcps_pkg::ONE_DUTY_RST;
		zero_cfg   = rlcps_pkg::ZERO_DUTY_RST;
		latch_cfg  = rlcps_pkg::LATCH_SLOTS_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed_codes();
		test_config_extremes();
		test_beyond_chain();
		test_random_phase(0, 0, 100);
		test_backpressure();
		test_random_phase(68, 0, 100);
		test_random_phase(0, 68, 100);
		test_random_phase(31, 31, 100);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (pending_slots.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_rgb_led_code_pwm_serializer: done, clean");
		end else begin
			$display("tb_rgb_led_code_pwm_serializer: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rlcps_pkg.sv
sv/rlcps_front.sv
sv/rlcps_cmd_fifo.sv
sv/rlcps_back.sv
sv/rgb_led_code_pwm_serializer.sv
dv/tb_rgb_led_code_pwm_serializer.sv
